### hw/rtl/rsi_pkg.sv
// Shared constants for the ray-sphere intersection core.
// Holds the pipeline sizes of the square root and divider units and the register indexes.
// No dependencies.
`timescale 1ns / 1ps

package rsi_pkg;

    // Square root unit: root bits, one per stage, and the radicand width.
    localparam int SQ_N = 54;
    localparam int SQ_W = 2 * SQ_N;

    // Normal divider: quotient bits, one per stage, and operand widths.
    localparam int DIV_Q_W   = 17;
    localparam int DIV_DEN_W = 34;
    localparam int DIV_NUM_W = 50;

    // Full request latency from input register to output register.
    localparam int LATENCY = 7 + SQ_N + 8 + SQ_N + 1 + DIV_Q_W + 1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPHERE_RADIUS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE = 3'd4;

    // Q16.16 one, the largest normal component magnitude.
    localparam logic [DIV_Q_W-1:0] NORM_ONE = 17'd65536;

endpackage

### hw/rtl/ray_sphere_intersect_core.sv
// Ray-sphere intersection core, geometric method; Q16.16 points, Q2.16 unit vectors.
// Depends on rsi_pkg, rsi_sqrt and rsi_div.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one ray request: origin and direction.
//   Output channel (o_out_valid / i_out_ready) returns one result per ray, in order:
//   hit flag, distance, hit point and unit normal. A miss returns all zero fields.
//   The user writes sphere centre, radius and minimum distance through i_cfg_we,
//   i_cfg_index and i_cfg_data only while no request is in flight; not enforced.
// Timing:
//   One ray is accepted every cycle unless the output stalls. The pipeline depth
//   comes from the two square roots (54 stages each, one root bit per stage) and
//   the normal dividers (17 stages, one quotient bit per stage).
// Reset:
//   Synchronous, active low. It empties the pipeline and restores the register defaults:
//   centre 0, radius 1.0, minimum distance 66 (about 0.001).
// Stall:
//   When a result waits and the receiver is not ready, the whole pipeline holds;
//   o_in_ready drops in the same cycle and no request is lost or repeated.
`timescale 1ns / 1ps

module ray_sphere_intersect_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port
    input  logic                               i_cfg_we,
    input  logic [rsi_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [31:0]                        i_cfg_data,
    // Ray requests
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [31:0]                 i_origin_x,
    input  logic signed [31:0]                 i_origin_y,
    input  logic signed [31:0]                 i_origin_z,
    input  logic signed [17:0]                 i_dir_x,
    input  logic signed [17:0]                 i_dir_y,
    input  logic signed [17:0]                 i_dir_z,
    // Results
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_is_hit,
    output logic [30:0]                        o_hit_distance,
    output logic signed [31:0]                 o_point_x,
    output logic signed [31:0]                 o_point_y,
    output logic signed [31:0]                 o_point_z,
    output logic signed [17:0]                 o_normal_x,
    output logic signed [17:0]                 o_normal_y,
    output logic signed [17:0]                 o_normal_z
);

    localparam int SQ_N = rsi_pkg::SQ_N;
    localparam int QW   = rsi_pkg::DIV_Q_W;
    localparam int LAT  = rsi_pkg::LATENCY;

    typedef struct {
        logic signed [31:0] o [3];
        logic signed [17:0] d [3];
    } t_ray;

    typedef struct {
        logic               ok;
        logic signed [53:0] tca;
        t_ray               ray;
    } t_side_a;

    typedef struct {
        logic               hit;
        logic [30:0]        hdist;
        logic signed [31:0] p [3];
        logic               vneg [3];
        logic [32:0]        vmag [3];
    } t_side_b;

    typedef struct {
        logic               hit;
        logic [30:0]        hdist;
        logic signed [31:0] p [3];
        logic               vneg [3];
        logic               lz;
    } t_side_c;

    // Configuration registers
    logic signed [31:0] r_cx, r_cy, r_cz;
    logic [30:0]        r_rad;
    logic [15:0]        r_mind;

    logic               w_en;
    logic               r_vld [LAT];
    logic signed [31:0] w_c [3];
    t_ray               w_in_ray;

    // Front stages
    logic signed [33:0]  w_l [3];
    logic [33:0]         w_lmag [3];
    t_ray                r_s1_ray, r_s2_ray, r_s3_ray, r_s4_ray, r_s5_ray, r_s6_ray, r_s7_ray;
    logic signed [33:0]  r_s1_l [3];
    logic signed [51:0]  r_s2_ld [3];
    logic [67:0]         r_s2_lsq [3];
    logic [61:0]         r_s2_rr, r_s3_rr, r_s4_rr, r_s5_rr;
    logic signed [53:0]  r_s3_tca, r_s4_tca, r_s5_tca, r_s6_tca, r_s7_tca;
    logic [69:0]         r_s3_ll, r_s4_ll, r_s5_ll;
    logic [41:0]         r_s4_hh;
    logic [52:0]         r_s4_hl;
    logic [63:0]         r_s4_lo2;
    logic [105:0]        r_s5_tsq;
    logic [106:0]        r_s6_a;
    logic [101:0]        r_s6_bq;
    logic [107:0]        w_diff;
    logic [106:0]        r_s7_disc;
    logic                r_s7_ok;

    // First square root and its side line
    logic [SQ_N-1:0]     w_thc;
    t_side_a             r_sa [SQ_N];

    // Distance and hit point stages
    logic signed [55:0]  w_tca56, w_thc56, w_t0, w_t1, w_eps, w_t;
    logic                w_sel;
    logic [54:0]         r_t1_t;
    logic                r_t1_hit, r_t2_hit, r_t3_hit, r_t4_hit, r_t5_hit;
    t_ray                r_t1_ray, r_t2_ray;
    logic [55:0]         w_rnd;
    logic [39:0]         w_t16;
    logic [39:0]         r_t2_t16;
    logic [30:0]         r_t2_dist, r_t3_dist, r_t4_dist, r_t5_dist;
    logic signed [58:0]  r_t3_prod [3];
    logic signed [31:0]  r_t3_o [3], r_t4_o [3];
    logic signed [58:0]  w_pr [3];
    logic signed [42:0]  r_t4_sh [3];
    logic signed [43:0]  w_ps [3];
    logic signed [31:0]  w_psat [3];
    logic signed [31:0]  r_t5_p [3];
    logic signed [32:0]  w_v [3];
    t_side_b             r_t6_sb, r_t7_sb, r_t8_sb;
    logic [65:0]         r_t7_vsq [3];
    logic [67:0]         r_t8_vv;

    // Second square root, dividers and output
    logic [SQ_N-1:0]     w_len;
    t_side_b             r_sb [SQ_N];
    logic [rsi_pkg::DIV_NUM_W-1:0] r_u1_num [3];
    logic [rsi_pkg::DIV_DEN_W-1:0] r_u1_len;
    t_side_c             r_u1_sc;
    t_side_c             r_sc [QW];
    logic [QW-1:0]       w_quo [3];
    logic [QW-1:0]       w_qc [3];
    logic signed [17:0]  w_n [3];
    t_side_c             w_last;

    logic                r_o_hit;
    logic [30:0]         r_o_dist;
    logic signed [31:0]  r_o_p [3];
    logic signed [17:0]  r_o_n [3];

    assign w_c[0] = r_cx;
    assign w_c[1] = r_cy;
    assign w_c[2] = r_cz;

    assign w_in_ray.o[0] = i_origin_x;
    assign w_in_ray.o[1] = i_origin_y;
    assign w_in_ray.o[2] = i_origin_z;
    assign w_in_ray.d[0] = i_dir_x;
    assign w_in_ray.d[1] = i_dir_y;
    assign w_in_ray.d[2] = i_dir_z;

    // The whole pipeline advances unless a result is held by the receiver.
    assign w_en       = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready = w_en;

    // Configuration register writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx   <= '0;
            r_cy   <= '0;
            r_cz   <= '0;
            r_rad  <= 31'd65536;
            r_mind <= 16'd66;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rsi_pkg::REG_CENTER_X:      r_cx   <= i_cfg_data;
                rsi_pkg::REG_CENTER_Y:      r_cy   <= i_cfg_data;
                rsi_pkg::REG_CENTER_Z:      r_cz   <= i_cfg_data;
                rsi_pkg::REG_SPHERE_RADIUS: r_rad  <= i_cfg_data[30:0];
                rsi_pkg::REG_MIN_DISTANCE:  r_mind <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Front combinational pieces: L, its magnitude, discriminant borrow.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_l[i]    = {{2{w_c[i][31]}}, w_c[i]} - {{2{w_in_ray.o[i][31]}}, w_in_ray.o[i]};
            w_lmag[i] = r_s1_l[i][33] ? unsigned'(-r_s1_l[i]) : unsigned'(r_s1_l[i]);
        end
        w_diff = 108'(r_s6_a) - 108'(r_s6_bq);
    end

    // Stages 1 to 7: L, tca, |L|^2 and the discriminant.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_ray <= w_in_ray;
            for (int i = 0; i < 3; i++) begin
                r_s1_l[i]   <= w_l[i];
                r_s2_ld[i]  <= r_s1_l[i] * r_s1_ray.d[i];
                r_s2_lsq[i] <= w_lmag[i] * w_lmag[i];
            end
            r_s2_ray <= r_s1_ray;
            r_s2_rr  <= r_rad * r_rad;

            r_s3_tca <= 54'(r_s2_ld[0]) + 54'(r_s2_ld[1]) + 54'(r_s2_ld[2]);
            r_s3_ll  <= 70'(r_s2_lsq[0]) + 70'(r_s2_lsq[1]) + 70'(r_s2_lsq[2]);
            r_s3_rr  <= r_s2_rr;
            r_s3_ray <= r_s2_ray;

            // tca squared in three partial products.
            r_s4_hh  <= r_s3_tca[52:32] * r_s3_tca[52:32];
            r_s4_hl  <= r_s3_tca[52:32] * r_s3_tca[31:0];
            r_s4_lo2 <= r_s3_tca[31:0] * r_s3_tca[31:0];
            r_s4_tca <= r_s3_tca;
            r_s4_ll  <= r_s3_ll;
            r_s4_rr  <= r_s3_rr;
            r_s4_ray <= r_s3_ray;

            r_s5_tsq <= 106'({r_s4_hh, 64'b0}) + 106'({r_s4_hl, 33'b0}) + 106'(r_s4_lo2);
            r_s5_tca <= r_s4_tca;
            r_s5_ll  <= r_s4_ll;
            r_s5_rr  <= r_s4_rr;
            r_s5_ray <= r_s4_ray;

            r_s6_a   <= 107'(r_s5_tsq) + 107'({r_s5_rr, 32'b0});
            r_s6_bq  <= {r_s5_ll, 32'b0};
            r_s6_tca <= r_s5_tca;
            r_s6_ray <= r_s5_ray;

            // A ray behind the origin or outside the radius misses.
            r_s7_disc <= w_diff[106:0];
            r_s7_ok   <= !r_s6_tca[53] && !w_diff[107];
            r_s7_tca  <= r_s6_tca;
            r_s7_ray  <= r_s6_ray;
        end
    end

    // Half chord length.
    rsi_sqrt u_sqrt_thc (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (108'(r_s7_disc)),
        .o_root (w_thc)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sa[0].ok  <= r_s7_ok;
            r_sa[0].tca <= r_s7_tca;
            r_sa[0].ray <= r_s7_ray;
            for (int k = 1; k < SQ_N; k++) begin
                r_sa[k] <= r_sa[k-1];
            end
        end
    end

    // Pick the nearer root that lies beyond the minimum distance.
    always_comb begin
        w_tca56 = 56'(r_sa[SQ_N-1].tca);
        w_thc56 = $signed({2'b00, w_thc});
        w_t0    = w_tca56 - w_thc56;
        w_t1    = w_tca56 + w_thc56;
        w_eps   = $signed({24'b0, r_mind, 16'b0});
        priority if (w_t0 > w_eps) begin
            w_t   = w_t0;
            w_sel = 1'b1;
        end else if (w_t1 > w_eps) begin
            w_t   = w_t1;
            w_sel = 1'b1;
        end else begin
            w_t   = '0;
            w_sel = 1'b0;
        end
        w_rnd = {1'b0, r_t1_t} + 56'd32768;
        w_t16 = w_rnd[55:16];
    end

    // Hit point: round the scaled direction, add the origin, saturate; form the centre-to-point vector.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_pr[i] = r_t3_prod[i] + 59'sd32768;
            w_ps[i] = 44'(r_t4_o[i]) + 44'(r_t4_sh[i]);
            priority if (w_ps[i] > 44'sd2147483647) begin
                w_psat[i] = 32'sh7FFFFFFF;
            end else if (w_ps[i] < -44'sd2147483648) begin
                w_psat[i] = 32'sh80000000;
            end else begin
                w_psat[i] = w_ps[i][31:0];
            end
            w_v[i] = 33'(r_t5_p[i]) - 33'(w_c[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t1_t   <= w_t[54:0];
            r_t1_hit <= r_sa[SQ_N-1].ok && w_sel;
            r_t1_ray <= r_sa[SQ_N-1].ray;

            r_t2_t16  <= w_t16;
            r_t2_dist <= (w_t16 > 40'h7FFFFFFF) ? 31'h7FFFFFFF : w_t16[30:0];
            r_t2_hit  <= r_t1_hit;
            r_t2_ray  <= r_t1_ray;

            for (int i = 0; i < 3; i++) begin
                r_t3_prod[i] <= $signed({1'b0, r_t2_t16}) * r_t2_ray.d[i];
                r_t3_o[i]    <= r_t2_ray.o[i];
                r_t4_sh[i]   <= w_pr[i][58:16];
                r_t4_o[i]    <= r_t3_o[i];
                r_t5_p[i]    <= w_psat[i];
                r_t6_sb.p[i]    <= r_t5_p[i];
                r_t6_sb.vneg[i] <= w_v[i][32];
                r_t6_sb.vmag[i] <= w_v[i][32] ? unsigned'(-w_v[i]) : unsigned'(w_v[i]);
                r_t7_vsq[i]  <= r_t6_sb.vmag[i] * r_t6_sb.vmag[i];
            end
            r_t3_hit  <= r_t2_hit;
            r_t3_dist <= r_t2_dist;
            r_t4_hit  <= r_t3_hit;
            r_t4_dist <= r_t3_dist;
            r_t5_hit  <= r_t4_hit;
            r_t5_dist <= r_t4_dist;
            r_t6_sb.hit   <= r_t5_hit;
            r_t6_sb.hdist <= r_t5_dist;
            r_t7_sb <= r_t6_sb;

            r_t8_vv <= 68'(r_t7_vsq[0]) + 68'(r_t7_vsq[1]) + 68'(r_t7_vsq[2]);
            r_t8_sb <= r_t7_sb;
        end
    end

    // Length of the centre-to-point vector.
    rsi_sqrt u_sqrt_len (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (108'(r_t8_vv)),
        .o_root (w_len)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sb[0] <= r_t8_sb;
            for (int k = 1; k < SQ_N; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    // Divider operands: |v| scaled by one, plus half the length for rounding.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_u1_num[i] <= 50'({r_sb[SQ_N-1].vmag[i], 16'b0}) + 50'(w_len[33:1]);
                r_u1_sc.p[i]    <= r_sb[SQ_N-1].p[i];
                r_u1_sc.vneg[i] <= r_sb[SQ_N-1].vneg[i];
            end
            r_u1_len      <= w_len[33:0];
            r_u1_sc.hit   <= r_sb[SQ_N-1].hit;
            r_u1_sc.hdist <= r_sb[SQ_N-1].hdist;
            r_u1_sc.lz    <= (w_len == '0);
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_norm
        rsi_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_u1_num[g]),
            .i_den (r_u1_len),
            .o_quo (w_quo[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sc[0] <= r_u1_sc;
            for (int k = 1; k < QW; k++) begin
                r_sc[k] <= r_sc[k-1];
            end
        end
    end

    // Clamp and sign the normal components.
    always_comb begin
        w_last = r_sc[QW-1];
        for (int i = 0; i < 3; i++) begin
            w_qc[i] = (w_quo[i] > rsi_pkg::NORM_ONE) ? rsi_pkg::NORM_ONE : w_quo[i];
            w_n[i]  = w_last.vneg[i] ? -$signed({1'b0, w_qc[i]}) : $signed({1'b0, w_qc[i]});
        end
    end

    // Output register; a miss clears every field.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_hit  <= w_last.hit;
            r_o_dist <= w_last.hit ? w_last.hdist : '0;
            for (int i = 0; i < 3; i++) begin
                r_o_p[i] <= w_last.hit ? w_last.p[i] : '0;
                r_o_n[i] <= (w_last.hit && !w_last.lz) ? w_n[i] : '0;
            end
        end
    end

    assign o_out_valid    = r_vld[LAT-1];
    assign o_is_hit       = r_o_hit;
    assign o_hit_distance = r_o_dist;
    assign o_point_x      = r_o_p[0];
    assign o_point_y      = r_o_p[1];
    assign o_point_z      = r_o_p[2];
    assign o_normal_x     = r_o_n[0];
    assign o_normal_y     = r_o_n[1];
    assign o_normal_z     = r_o_n[2];

    // A held result must block new requests.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("request accepted while a result is held");

    // A miss carries no distance or point.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_hit |-> o_hit_distance == '0 && o_point_x == '0
            && o_point_y == '0 && o_point_z == '0 && o_normal_x == '0)
        else $error("miss result has nonzero fields");

    // Normal x and y components never exceed one in magnitude.
    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_normal_x <= 18'sd65536 && o_normal_x >= -18'sd65536)
            && (o_normal_y <= 18'sd65536 && o_normal_y >= -18'sd65536))
        else $error("normal component out of range");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

### hw/rtl/rsi_sqrt.sv
// Pipelined floor square root, one root bit resolved per register stage.
// Depends on rsi_pkg for the root and radicand widths.
`timescale 1ns / 1ps

module rsi_sqrt (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [rsi_pkg::SQ_W-1:0]   i_rad,
    output logic [rsi_pkg::SQ_N-1:0]   o_root
);

    localparam int RW = rsi_pkg::SQ_N + 2;

    logic [RW-1:0]            r_rem  [rsi_pkg::SQ_N];
    logic [rsi_pkg::SQ_N-1:0] r_root [rsi_pkg::SQ_N];
    logic [rsi_pkg::SQ_W-1:0] r_rad  [rsi_pkg::SQ_N];

    genvar k;
    for (k = 0; k < rsi_pkg::SQ_N; k++) begin : g_stage
        logic [RW-1:0]            w_rem;
        logic [rsi_pkg::SQ_N-1:0] w_root;
        logic [rsi_pkg::SQ_W-1:0] w_rad;
        logic [RW+1:0]            w_sh;
        logic [RW+1:0]            w_trial;
        logic [RW+1:0]            w_diff;
        logic                     w_ge;
        logic [RW-1:0]            n_rem;
        logic [rsi_pkg::SQ_N-1:0] n_root;
        logic [rsi_pkg::SQ_W-1:0] n_rad;

        if (k == 0) begin : g_first
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_rad  = i_rad;
        end else begin : g_next
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
            assign w_rad  = r_rad[k-1];
        end

        // Bring down two radicand bits and try the next root bit.
        always_comb begin
            w_sh    = {w_rem, w_rad[rsi_pkg::SQ_W-1 -: 2]};
            w_trial = {2'b00, w_root, 2'b01};
            w_ge    = (w_sh >= w_trial);
            w_diff  = w_sh - w_trial;
            n_rem   = w_ge ? w_diff[RW-1:0] : w_sh[RW-1:0];
            n_root  = {w_root[rsi_pkg::SQ_N-2:0], w_ge};
            n_rad   = {w_rad[rsi_pkg::SQ_W-3:0], 2'b00};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_rad[k]  <= n_rad;
            end
        end
    end

    assign o_root = r_root[rsi_pkg::SQ_N-1];

endmodule

### hw/rtl/rsi_div.sv
// Pipelined restoring divider for the normal components, one quotient bit per stage.
// Depends on rsi_pkg for operand widths; the quotient must fit in DIV_Q_W bits.
`timescale 1ns / 1ps

module rsi_div (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [rsi_pkg::DIV_NUM_W-1:0]   i_num,
    input  logic [rsi_pkg::DIV_DEN_W-1:0]   i_den,
    output logic [rsi_pkg::DIV_Q_W-1:0]     o_quo
);

    localparam int QW = rsi_pkg::DIV_Q_W;
    localparam int DW = rsi_pkg::DIV_DEN_W;

    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_lo  [QW];
    logic [QW-1:0] r_quo [QW];
    logic [DW-1:0] r_den [QW];

    genvar k;
    for (k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] w_rem;
        logic [QW-1:0] w_lo;
        logic [QW-1:0] w_quo;
        logic [DW-1:0] w_den;
        logic [DW:0]   w_sh;
        logic [DW:0]   w_diff;
        logic          w_ge;
        logic [DW-1:0] n_rem;

        if (k == 0) begin : g_first
            // The upper numerator bits are already below the divisor.
            assign w_rem = DW'(i_num[rsi_pkg::DIV_NUM_W-1:QW]);
            assign w_lo  = i_num[QW-1:0];
            assign w_quo = '0;
            assign w_den = i_den;
        end else begin : g_next
            assign w_rem = r_rem[k-1];
            assign w_lo  = r_lo[k-1];
            assign w_quo = r_quo[k-1];
            assign w_den = r_den[k-1];
        end

        // Shift in one numerator bit and subtract the divisor if it fits.
        always_comb begin
            w_sh   = {w_rem, w_lo[QW-1]};
            w_ge   = (w_sh >= {1'b0, w_den});
            w_diff = w_sh - {1'b0, w_den};
            n_rem  = w_ge ? w_diff[DW-1:0] : w_sh[DW-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_lo[k]  <= {w_lo[QW-2:0], 1'b0};
                r_quo[k] <= {w_quo[QW-2:0], w_ge};
                r_den[k] <= w_den;
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule
